[rtl/rational_arithmetic_unit_macros.svh]
// Assertion macros shared by the checker of the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define RAU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define RAU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/rau_pkg.sv]
// Types, codes and the step program of the rational arithmetic unit.
package rau_pkg;

	localparam logic [63:0] MASK63  = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] TOP_BIT = 64'h8000_0000_0000_0000;

	typedef enum logic [2:0] {
		OP_NORM = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4
	} rau_op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OVF   = 2'd1,
		ST_ZERO  = 2'd2,
		ST_INVAL = 2'd3
	} rau_status_t;

	typedef enum logic [1:0] {U_GCD, U_DIV, U_MUL, U_SUM} rau_uop_t;

	typedef enum logic [3:0] {
		S_MA, S_MB, S_AD, S_BD, S_T0, S_T1, S_T2, S_T3, S_ONE
	} rau_src_t;

	typedef enum logic [1:0] {L_POS, L_RS, L_NA, L_NB} rau_lim_t;

	typedef struct packed {
		rau_uop_t   uop;
		rau_src_t   sx;
		rau_src_t   sy;
		logic [1:0] dst;
		rau_lim_t   lim;
		logic       last;
	} rau_step_t;

	typedef struct packed {
		logic      go;
		rau_step_t step;
	} rau_cmd_t;

	typedef struct packed {
		logic step_done;
		logic pre_bad;
	} rau_stat_t;

	function automatic rau_step_t mk(rau_uop_t u, rau_src_t x, rau_src_t y,
		logic [1:0] d, rau_lim_t l, logic e);
		rau_step_t s;
		s.uop = u; s.sx = x; s.sy = y; s.dst = d; s.lim = l; s.last = e;
		return s;
	endfunction

	// Step program per operation; numerator ends in T2, denominator in T3.
	function automatic rau_step_t prog(logic [2:0] op, logic [3:0] pc);
		rau_step_t s;
		s = mk(U_SUM, S_T0, S_T0, 2'd0, L_POS, 1'b1);
		case (op)
			OP_NORM: begin
				case (pc)
					4'd0: s = mk(U_GCD, S_MA, S_AD, 2'd0, L_POS, 1'b0);
					4'd1: s = mk(U_DIV, S_MA, S_T0, 2'd2, L_POS, 1'b0);
					4'd2: s = mk(U_DIV, S_AD, S_T0, 2'd3, L_POS, 1'b0);
					4'd3: s = mk(U_MUL, S_T2, S_ONE, 2'd2, L_RS, 1'b0);
					default: s = mk(U_MUL, S_T3, S_ONE, 2'd3, L_POS, 1'b1);
				endcase
			end
			OP_ADD, OP_SUB: begin
				case (pc)
					4'd0: s = mk(U_GCD, S_AD, S_BD, 2'd0, L_POS, 1'b0);
					4'd1: s = mk(U_DIV, S_BD, S_T0, 2'd1, L_POS, 1'b0);
					4'd2: s = mk(U_DIV, S_AD, S_T0, 2'd2, L_POS, 1'b0);
					4'd3: s = mk(U_MUL, S_MA, S_T1, 2'd1, L_NA, 1'b0);
					4'd4: s = mk(U_MUL, S_MB, S_T2, 2'd3, L_NB, 1'b0);
					4'd5: s = mk(U_SUM, S_T1, S_T3, 2'd1, L_POS, 1'b0);
					4'd6: s = mk(U_GCD, S_T1, S_T0, 2'd0, L_POS, 1'b0);
					4'd7: s = mk(U_DIV, S_BD, S_T0, 2'd3, L_POS, 1'b0);
					4'd8: s = mk(U_MUL, S_T2, S_T3, 2'd3, L_POS, 1'b0);
					default: s = mk(U_DIV, S_T1, S_T0, 2'd2, L_POS, 1'b1);
				endcase
			end
			OP_MUL: begin
				case (pc)
					4'd0: s = mk(U_GCD, S_MA, S_BD, 2'd0, L_POS, 1'b0);
					4'd1: s = mk(U_GCD, S_MB, S_AD, 2'd1, L_POS, 1'b0);
					4'd2: s = mk(U_DIV, S_MA, S_T0, 2'd2, L_POS, 1'b0);
					4'd3: s = mk(U_DIV, S_MB, S_T1, 2'd3, L_POS, 1'b0);
					4'd4: s = mk(U_MUL, S_T2, S_T3, 2'd2, L_RS, 1'b0);
					4'd5: s = mk(U_DIV, S_AD, S_T1, 2'd1, L_POS, 1'b0);
					4'd6: s = mk(U_DIV, S_BD, S_T0, 2'd0, L_POS, 1'b0);
					default: s = mk(U_MUL, S_T1, S_T0, 2'd3, L_POS, 1'b1);
				endcase
			end
			default: begin
				case (pc)
					4'd0: s = mk(U_GCD, S_MA, S_MB, 2'd0, L_POS, 1'b0);
					4'd1: s = mk(U_GCD, S_AD, S_BD, 2'd1, L_POS, 1'b0);
					4'd2: s = mk(U_DIV, S_MA, S_T0, 2'd2, L_POS, 1'b0);
					4'd3: s = mk(U_DIV, S_BD, S_T1, 2'd3, L_POS, 1'b0);
					4'd4: s = mk(U_MUL, S_T2, S_T3, 2'd2, L_RS, 1'b0);
					4'd5: s = mk(U_DIV, S_AD, S_T1, 2'd1, L_POS, 1'b0);
					4'd6: s = mk(U_DIV, S_MB, S_T0, 2'd0, L_POS, 1'b0);
					default: s = mk(U_MUL, S_T1, S_T0, 2'd3, L_POS, 1'b1);
				endcase
			end
		endcase
		return s;
	endfunction

endpackage

[rtl/rau_datapath.sv]
// Datapath: operand registers, shared GCD/divide/multiply/sum unit, result shaping.
module rau_datapath import rau_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic [2:0]  req_type,
	input  logic [63:0] a_num,
	input  logic [63:0] a_den,
	input  logic [63:0] b_num,
	input  logic [62:0] b_den,
	input  rau_cmd_t    cmd,
	output rau_stat_t   stat,
	output logic [63:0] res_num,
	output logic [62:0] res_den,
	output logic [1:0]  status
);

	logic [63:0] ma_q, mb_q, ad_q, bd_q, t0_q, t1_q, t2_q, t3_q;
	logic        na_q, nb_q, rs_q, sub_q, ovf_q, run_q;
	rau_status_t pre_q, pre;
	rau_uop_t    uop_q;
	logic [1:0]  dst_q;
	rau_lim_t    lim_q;
	logic [63:0] wa_q, wb_q, wx_q;
	logic [5:0]  cnt_q;

	logic [63:0] x, y, lim, wval, ma_in, ad_in, mb_in, p_lo, tm;
	logic        fin, set_ovf, set_rs, new_rs, n2;
	logic [64:0] tdiv, msum, psum;

	function automatic logic [63:0] src(rau_src_t s, logic [63:0] ma, logic [63:0] mb,
		logic [63:0] ad, logic [63:0] bd, logic [63:0] t0, logic [63:0] t1,
		logic [63:0] t2, logic [63:0] t3);
		logic [63:0] v;
		case (s)
			S_MA: v = ma;
			S_MB: v = mb;
			S_AD: v = ad;
			S_BD: v = bd;
			S_T0: v = t0;
			S_T1: v = t1;
			S_T2: v = t2;
			S_T3: v = t3;
			default: v = 64'd1;
		endcase
		return v;
	endfunction

	assign ma_in = a_num[63] ? (~a_num + 64'd1) : a_num;
	assign mb_in = b_num[63] ? (~b_num + 64'd1) : b_num;
	assign ad_in = a_den[63] ? (~a_den + 64'd1) : a_den;

	// Operand checks made before any step runs.
	always_comb begin
		pre = ST_OK;
		if (req_type > 3'(OP_DIV))
			pre = ST_INVAL;
		else if (req_type == 3'(OP_NORM)) begin
			if (a_den == 64'd0) pre = ST_ZERO;
		end else if (a_den[63] || a_den == 64'd0 || b_den == 63'd0)
			pre = ST_INVAL;
		else if (req_type == 3'(OP_DIV) && b_num == 64'd0)
			pre = ST_ZERO;
	end

	assign x = src(cmd.step.sx, ma_q, mb_q, ad_q, bd_q, t0_q, t1_q, t2_q, t3_q);
	assign y = src(cmd.step.sy, ma_q, mb_q, ad_q, bd_q, t0_q, t1_q, t2_q, t3_q);

	always_comb begin
		case (lim_q)
			L_POS:   lim = MASK63;
			L_RS:    lim = rs_q ? TOP_BIT : MASK63;
			L_NA:    lim = na_q ? TOP_BIT : MASK63;
			default: lim = nb_q ? TOP_BIT : MASK63;
		endcase
	end

	assign tdiv = {wa_q, wb_q[63]};
	assign msum = {1'b0, wa_q} + (wb_q[0] ? {1'b0, wx_q} : 65'd0);
	assign p_lo = {msum[0], wb_q[63:1]};
	assign n2   = sub_q ? ~nb_q : nb_q;
	assign psum = {1'b0, wa_q} + {1'b0, wb_q};

	// Finish condition and write-back value of the running step.
	always_comb begin
		fin = 1'b0; wval = 64'd0; set_ovf = 1'b0; set_rs = 1'b0; new_rs = 1'b0; tm = 64'd0;
		if (run_q) begin
			case (uop_q)
				U_GCD: begin
					fin  = (wa_q == 64'd0) || (wb_q == 64'd0);
					wval = (wa_q | wb_q) << cnt_q;
				end
				U_DIV: begin
					fin  = (cnt_q == 6'd63);
					wval = {wb_q[62:0], (tdiv >= {1'b0, wx_q})};
				end
				U_MUL: begin
					fin     = (cnt_q == 6'd63);
					wval    = p_lo;
					set_ovf = fin && ((msum[64:1] != 64'd0) || (p_lo > lim));
				end
				default: begin
					fin    = 1'b1;
					set_rs = 1'b1;
					if (na_q == n2) begin
						new_rs  = na_q;
						tm      = psum[63:0];
						set_ovf = psum > {1'b0, (na_q ? TOP_BIT : MASK63)};
					end else if (wa_q >= wb_q) begin
						new_rs = na_q;
						tm     = wa_q - wb_q;
					end else begin
						new_rs = n2;
						tm     = wb_q - wa_q;
					end
					wval = tm;
				end
			endcase
		end
	end

	assign stat.step_done = fin;
	assign stat.pre_bad   = (pre != ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			ovf_q <= 1'b0;
			pre_q <= ST_OK;
		end else if (load) begin
			ma_q  <= ma_in;
			mb_q  <= mb_in;
			ad_q  <= ad_in;
			bd_q  <= {1'b0, b_den};
			na_q  <= a_num[63];
			nb_q  <= b_num[63];
			sub_q <= (req_type == 3'(OP_SUB));
			rs_q  <= (req_type == 3'(OP_NORM)) ? (a_num[63] ^ a_den[63])
			                                   : (a_num[63] ^ b_num[63]);
			ovf_q <= 1'b0;
			pre_q <= pre;
			run_q <= 1'b0;
		end else if (cmd.go) begin
			run_q <= 1'b1;
			uop_q <= cmd.step.uop;
			dst_q <= cmd.step.dst;
			lim_q <= cmd.step.lim;
			cnt_q <= 6'd0;
			case (cmd.step.uop)
				U_DIV: begin
					wa_q <= 64'd0; wb_q <= x; wx_q <= y;
				end
				U_MUL: begin
					wa_q <= 64'd0; wb_q <= y; wx_q <= x;
				end
				default: begin
					wa_q <= x; wb_q <= y;
				end
			endcase
		end else if (run_q) begin
			if (fin) begin
				run_q <= 1'b0;
				case (dst_q)
					2'd0:    t0_q <= wval;
					2'd1:    t1_q <= wval;
					2'd2:    t2_q <= wval;
					default: t3_q <= wval;
				endcase
				if (set_ovf) ovf_q <= 1'b1;
				if (set_rs) rs_q <= new_rs;
			end else begin
				case (uop_q)
					U_GCD: begin
						// Binary GCD: strip common twos, then odd-odd subtract.
						if (!wa_q[0] && !wb_q[0]) begin
							wa_q <= wa_q >> 1; wb_q <= wb_q >> 1; cnt_q <= cnt_q + 6'd1;
						end else if (!wa_q[0])
							wa_q <= wa_q >> 1;
						else if (!wb_q[0])
							wb_q <= wb_q >> 1;
						else if (wa_q >= wb_q)
							wa_q <= wa_q - wb_q;
						else
							wb_q <= wb_q - wa_q;
					end
					U_DIV: begin
						if (tdiv >= {1'b0, wx_q})
							wa_q <= 64'(tdiv - {1'b0, wx_q});
						else
							wa_q <= tdiv[63:0];
						wb_q  <= wval;
						cnt_q <= cnt_q + 6'd1;
					end
					default: begin
						wa_q  <= msum[64:1];
						wb_q  <= p_lo;
						cnt_q <= cnt_q + 6'd1;
					end
				endcase
			end
		end
	end

	always_comb begin
		if (pre_q != ST_OK)
			status = pre_q;
		else if (ovf_q)
			status = ST_OVF;
		else
			status = ST_OK;
	end

	assign res_num = (status != ST_OK) ? 64'd0 :
	                 ((rs_q && t2_q != 64'd0) ? (~t2_q + 64'd1) : t2_q);
	assign res_den = (status != ST_OK) ? 63'd0 : t3_q[62:0];

endmodule

[rtl/rau_ctrl.sv]
// Controller: sequences the step program of one request over the datapath.
module rau_ctrl import rau_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] req_type,
	input  rau_stat_t  stat,
	output logic       load,
	output rau_cmd_t   cmd,
	output logic       busy,
	output logic       done
);

	typedef enum logic [1:0] {IDLE, ISSUE, WAIT, FIN} state_t;

	state_t     state_q;
	logic [2:0] op_q;
	logic [3:0] pc_q;
	rau_step_t  step;

	assign step     = prog(op_q, pc_q);
	assign load     = start && (state_q == IDLE);
	assign cmd.go   = (state_q == ISSUE);
	assign cmd.step = step;
	assign busy     = (state_q != IDLE);
	assign done     = (state_q == FIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			op_q    <= 3'd0;
			pc_q    <= 4'd0;
		end else begin
			case (state_q)
				IDLE: begin
					if (start) begin
						op_q    <= req_type;
						pc_q    <= 4'd0;
						// skip the program when the operands are already rejected
						state_q <= stat.pre_bad ? FIN : ISSUE;
					end
				end
				ISSUE: state_q <= WAIT;
				WAIT: begin
					if (stat.step_done) begin
						if (step.last)
							state_q <= FIN;
						else begin
							pc_q    <= pc_q + 4'd1;
							state_q <= ISSUE;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

[rtl/rational_arithmetic_unit.sv]
// Top level of the rational arithmetic unit.
//
// Use: drive req_type, a_num, a_den, b_num, b_den and raise start; the beat is
// taken at the rising edge where start is high and busy is low. busy then stays
// high until the result beat has been shown. The result beat (res_num, res_den,
// status) is valid for exactly one cycle while done is high; the receiver cannot
// stall it, so capture it on that cycle.
// A rejected request (bad selector, bad or zero denominator, zero divisor) shows
// done in the cycle right after acceptance. Otherwise the controller walks a step
// program of 5 to 10 steps over one shared unit; each step is issued and then runs
// a binary GCD, a restoring divide, a shift-add multiply or a signed sum until it
// finishes. One request is in flight at a time; the next can start the cycle
// after done.
// Reset (arst_n low) returns the controller to idle and drops any request.
module rational_arithmetic_unit import rau_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [63:0] a_num,
	input  logic [63:0] a_den,
	input  logic [63:0] b_num,
	input  logic [62:0] b_den,
	output logic        done,
	output logic [63:0] res_num,
	output logic [62:0] res_den,
	output logic [1:0]  status
);

	logic      load;
	rau_cmd_t  cmd;
	rau_stat_t stat;

	// Sequence the steps; hold the program counter while a step runs.
	rau_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.stat     (stat),
		.load     (load),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	// Hold operands and temporaries; run one GCD, divide, multiply or sum per step.
	rau_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.req_type (req_type),
		.a_num    (a_num),
		.a_den    (a_den),
		.b_num    (b_num),
		.b_den    (b_den),
		.cmd      (cmd),
		.stat     (stat),
		.res_num  (res_num),
		.res_den  (res_den),
		.status   (status)
	);

endmodule

[rtl/rau_checker.sv]
// Port-level checks of the rational arithmetic unit, bound to the top level.
`include "rational_arithmetic_unit_macros.svh"

module rau_checker import rau_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [63:0] res_num,
	input logic [62:0] res_den,
	input logic [1:0]  status
);

	`RAU_ASSERT_NXT(a_accept_busy, start && !busy, busy)
	`RAU_ASSERT_IMP(a_done_busy, done, busy)
	`RAU_ASSERT_NXT(a_done_single, done, !done && !busy)
	`RAU_ASSERT_IMP(a_err_zero, done && status != ST_OK, res_num == 64'd0 && res_den == 63'd0)
	`RAU_ASSERT_IMP(a_ok_den, done && status == ST_OK, res_den != 63'd0)

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);

[tb/testbench.sv]
// Self-checking testbench of the rational arithmetic unit.
module testbench;
	import rau_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [2:0]  op;
		logic [63:0] an;
		logic [63:0] ad;
		logic [63:0] bn;
		logic [62:0] bd;
	} rat_req_t;

	typedef struct {
		logic [63:0] num;
		logic [62:0] den;
		logic [1:0]  st;
	} rat_res_t;

	localparam logic [63:0] LIM_POS = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] LIM_NEG = 64'h8000_0000_0000_0000;
	localparam int unsigned N_RANDOM = 1150;
	localparam longint unsigned CYCLE_LIMIT = 4000000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  req_type;
	logic [63:0] a_num;
	logic [63:0] a_den;
	logic [63:0] b_num;
	logic [62:0] b_den;
	logic        done;
	logic [63:0] res_num;
	logic [62:0] res_den;
	logic [1:0]  status;

	rat_req_t pending_reqs[$];
	rat_res_t expected_results[$];
	bit       stimulus_done;
	int       n_errors;
	longint unsigned n_cycles;

	rational_arithmetic_unit i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .a_num(a_num), .a_den(a_den), .b_num(b_num),
		.b_den(b_den), .done(done), .res_num(res_num), .res_den(res_den),
		.status(status)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Magnitude of a two's complement word; the most negative word maps to 2^63.
	function automatic logic [63:0] mag64(logic [63:0] x);
		return x[63] ? (~x + 64'd1) : x;
	endfunction

	function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
		logic [63:0] r;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	function automatic logic [63:0] sign_lim(bit neg);
		return neg ? LIM_NEG : LIM_POS;
	endfunction

	// Product of magnitudes; returns 0 when it leaves the signed range for neg.
	function automatic bit mul_in_range(logic [63:0] m1, logic [63:0] m2, bit neg,
		output logic [63:0] p);
		logic [127:0] full;
		full = m1 * m2;
		p = full[63:0];
		return full <= {64'd0, sign_lim(neg)};
	endfunction

	function automatic rat_res_t pack_res(rau_status_t st, bit neg, logic [63:0] nm,
		logic [63:0] dm);
		rat_res_t r;
		r.st = st;
		if (st != ST_OK) begin
			r.num = '0;
			r.den = '0;
		end else begin
			r.num = (neg && nm != 0) ? (~nm + 64'd1) : nm;
			r.den = dm[62:0];
		end
		return r;
	endfunction

	// Compute the canonical rational result of one request.
	function automatic rat_res_t rational_result(rat_req_t q);
		logic [63:0] ma, mb, md, bd, g, g1, g2, rn, rd, d, da, db, p1, p2, tm;
		bit na, nb, neg, n2, tn;
		ma = mag64(q.an);
		mb = mag64(q.bn);
		na = q.an[63];
		nb = q.bn[63];
		bd = {1'b0, q.bd};
		if (q.op > OP_DIV)
			return pack_res(ST_INVAL, 0, 0, 0);
		if (q.op == OP_NORM) begin
			if (q.ad == 0)
				return pack_res(ST_ZERO, 0, 0, 0);
			md = mag64(q.ad);
			neg = na != q.ad[63];
			g = gcd64(ma, md);
			rn = ma / g;
			rd = md / g;
			if (rn > sign_lim(neg && rn != 0) || rd > LIM_POS)
				return pack_res(ST_OVF, 0, 0, 0);
			return pack_res(ST_OK, neg, rn, rd);
		end
		if (q.ad[63] || q.ad == 0 || bd == 0)
			return pack_res(ST_INVAL, 0, 0, 0);
		if (q.op == OP_ADD || q.op == OP_SUB) begin
			d = gcd64(q.ad, bd);
			db = bd / d;
			da = q.ad / d;
			if (!mul_in_range(ma, db, na, p1) || !mul_in_range(mb, da, nb, p2))
				return pack_res(ST_OVF, 0, 0, 0);
			n2 = (q.op == OP_SUB) ? !nb : nb;
			if (na == n2) begin
				tn = na;
				if (p1 > sign_lim(tn) - p2 || p1 + p2 > sign_lim(tn))
					return pack_res(ST_OVF, 0, 0, 0);
				tm = p1 + p2;
			end else if (p1 >= p2) begin
				tn = na;
				tm = p1 - p2;
			end else begin
				tn = n2;
				tm = p2 - p1;
			end
			g = gcd64(tm, d);
			rn = tm / g;
			if (!mul_in_range(da, bd / g, 0, rd))
				return pack_res(ST_OVF, 0, 0, 0);
			return pack_res(ST_OK, tn, rn, rd);
		end
		neg = na != nb;
		if (q.op == OP_MUL) begin
			g1 = gcd64(ma, bd);
			g2 = gcd64(mb, q.ad);
			if (!mul_in_range(ma / g1, mb / g2, neg, rn) ||
				!mul_in_range(q.ad / g2, bd / g1, 0, rd))
				return pack_res(ST_OVF, 0, 0, 0);
			return pack_res(ST_OK, neg, rn, rd);
		end
		if (q.bn == 0)
			return pack_res(ST_ZERO, 0, 0, 0);
		g1 = gcd64(ma, mb);
		g2 = gcd64(q.ad, bd);
		if (!mul_in_range(ma / g1, bd / g2, neg, rn) ||
			!mul_in_range(q.ad / g2, mb / g1, 0, rd))
			return pack_res(ST_OVF, 0, 0, 0);
		return pack_res(ST_OK, neg, rn, rd);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Operand of a random size class: tiny, small, medium width, or full width.
	function automatic logic [63:0] rand_val();
		logic [63:0] v;
		int unsigned w;
		case ($urandom_range(0, 9))
			0, 1, 2: v = 64'($urandom_range(0, 40));
			3, 4, 5: v = 64'($urandom_range(0, 100000));
			6, 7: begin
				w = $urandom_range(1, 40);
				v = rand64() & ((64'd1 << w) - 64'd1);
			end
			default: v = rand64();
		endcase
		return v;
	endfunction

	// Multiply by a shared factor so that reductions actually happen.
	function automatic logic [63:0] scaled(logic [63:0] v, logic [63:0] f);
		return ($urandom_range(0, 1) && v < 64'h1_0000_0000) ? v * f : v;
	endfunction

	task automatic push_req(logic [2:0] op, logic [63:0] an, logic [63:0] ad,
		logic [63:0] bn, logic [62:0] bd);
		rat_req_t q;
		q.op = op; q.an = an; q.ad = ad; q.bn = bn; q.bd = bd;
		pending_reqs.push_back(q);
	endtask

	task automatic push_random();
		logic [63:0] an, ad, bn, bd, f;
		logic [2:0] op;
		f = 64'($urandom_range(1, 5000));
		op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
			: 3'($urandom_range(OP_NORM, OP_DIV));
		an = scaled(rand_val(), f);
		bn = scaled(rand_val(), f);
		if ($urandom_range(0, 1)) an = -an;
		if ($urandom_range(0, 1)) bn = -bn;
		ad = scaled(rand_val(), f);
		bd = scaled(rand_val(), f);
		// Mostly well-formed operands so most beats reach the arithmetic.
		if ($urandom_range(0, 9) != 0) begin
			ad[63] = 1'b0;
			if (ad == 0) ad = 1;
			if (bd[62:0] == 0) bd = 1;
		end
		if (op == OP_NORM && $urandom_range(0, 1)) ad = -ad;
		if ($urandom_range(0, 7) == 0) bd = 1;
		push_req(op, an, ad, bn, bd[62:0]);
	endtask

	// Stimulus: directed corner beats first, then random traffic.
	initial begin
		push_req(OP_NORM, 64'd6, 64'd4, 64'd0, 63'd0);
		push_req(OP_NORM, 64'd6, -64'd4, 64'd0, 63'd0);
		push_req(OP_NORM, 64'd5, 64'd0, 64'd0, 63'd1);
		push_req(OP_NORM, LIM_NEG, -64'd1, 64'd0, 63'd1);
		push_req(OP_NORM, LIM_NEG, -64'd2, 64'd0, 63'd1);
		push_req(OP_NORM, LIM_NEG, LIM_NEG, 64'd0, 63'd1);
		push_req(OP_NORM, 64'd0, LIM_NEG, 64'd0, 63'd1);
		push_req(OP_NORM, LIM_POS, LIM_NEG, 64'd0, 63'd1);
		push_req(OP_ADD, 64'd1, 64'd2, 64'd1, 63'd3);
		push_req(OP_SUB, 64'd1, 64'd6, 64'd1, 63'd3);
		push_req(OP_ADD, LIM_POS, 64'd1, 64'd1, 63'd1);
		push_req(OP_SUB, LIM_NEG, 64'd1, 64'd1, 63'd1);
		push_req(OP_ADD, LIM_NEG, 64'd1, LIM_POS, 63'd1);
		push_req(OP_ADD, LIM_POS, 64'd3, LIM_POS, 63'h7FFF_FFFF_FFFF_FFFF);
		push_req(OP_MUL, 64'd3, 64'd4, 64'd8, 63'd9);
		push_req(OP_MUL, LIM_NEG, 64'd1, -64'd1, 63'd1);
		push_req(OP_MUL, LIM_NEG, 64'd1, 64'd1, 63'd1);
		push_req(OP_DIV, 64'd3, 64'd4, -64'd9, 63'd8);
		push_req(OP_DIV, 64'd3, 64'd4, 64'd0, 63'd8);
		push_req(OP_DIV, LIM_NEG, 64'd1, LIM_NEG, 63'h7FFF_FFFF_FFFF_FFFF);
		push_req(OP_ADD, 64'd1, 64'd0, 64'd1, 63'd1);
		push_req(OP_MUL, 64'd1, -64'd3, 64'd1, 63'd1);
		push_req(OP_DIV, 64'd1, 64'd1, 64'd1, 63'd0);
		push_req(3'd5, 64'd1, 64'd1, 64'd1, 63'd1);
		push_req(3'd7, '1, '1, '1, '1);
		repeat (N_RANDOM) push_random();
	end

	// Driver: burst and gap pacing; hold the beat until busy is low at an edge.
	int unsigned burst_left;
	int unsigned gap_left;
	rat_req_t    cur_req;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req_type <= '0;
			a_num <= '0;
			a_den <= '0;
			b_num <= '0;
			b_den <= '0;
			burst_left <= 0;
			gap_left <= 0;
			stimulus_done <= 1'b0;
		end else begin
			if (start && !busy) begin
				// The beat is taken now; note what it should produce.
				expected_results.push_back(rational_result(cur_req));
			end
			if (start && busy) begin
				// Hold the beat steady until it is taken.
			end else if (gap_left != 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_reqs.size() != 0) begin
				cur_req = pending_reqs.pop_front();
				start <= 1'b1;
				req_type <= cur_req.op;
				a_num <= cur_req.an;
				a_den <= cur_req.ad;
				b_num <= cur_req.bn;
				b_den <= cur_req.bd;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 12);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				start <= 1'b0;
				stimulus_done <= 1'b1;
			end
		end
	end

	// Monitor: take the one-cycle result beat and compare it with the oldest expectation.
	always @(posedge clk) begin
		rat_res_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result num=%h den=%h status=%0d",
					$time, res_num, res_den, status);
				n_errors++;
			end else begin
				want = expected_results.pop_front();
				if (res_num !== want.num || res_den !== want.den || status !== want.st) begin
					$display("%0t: mismatch expected num=%h den=%h status=%0d",
						$time, want.num, want.den, want.st);
					$display("%0t:          actual   num=%h den=%h status=%0d",
						$time, res_num, res_den, status);
					n_errors++;
				end
			end
		end
	end

	// Watchdog: end the run if the block stops answering.
	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		n_errors = 0;
		n_cycles = 0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		wait (stimulus_done && !start && expected_results.size() == 0);
		// Drain: let any stray result show up before the verdict.
		repeat (1000) @(posedge clk);
		if (n_errors == 0 && expected_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
